// ----- hdl/jd2c_pkg.sv -----
// Shared constants and tables for the Julian day to calendar date converter.
// No dependencies.
package jd2c_pkg;

	// word widths
	localparam int JD_W       = 39;
	localparam int DAY_W      = 5;
	localparam int MONTH_W    = 4;
	localparam int YEAR_W     = 16;
	localparam int FRAC_OUT_W = 16;

	localparam int FRAC_BITS_DEFAULT = 16;

	// digit width of the constant long dividers
	localparam int DIGIT_W = 4;

	// calendar constants
	localparam int GREG_START = 2299161;
	localparam int ALPHA_OFS  = 7468865;  // 4 * 1867216.25
	localparam int ALPHA_DIV  = 146097;   // 4 * 36524.25
	localparam int B_OFS      = 1524;
	localparam int C_OFS      = 12210;    // 100 * 122.1
	localparam int C_DIV      = 36525;    // 100 * 365.25
	localparam int D_MUL      = 1461;     // 4 * 365.25
	localparam int YEAR_OFS_LATE  = 4716;
	localparam int YEAR_OFS_EARLY = 4715;

	// b - d is always in 123..488, so 9 bits of it carry the whole value
	localparam int BD_W = 9;

	// floor(30.6001 * e) for e = 0..15; for e >= 1 none is exact, so the
	// threshold ceil(30.6001 * e) is this value plus one
	localparam logic [BD_W-1:0] DAY_OFS [16] = '{
		9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
		9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
	};

endpackage

// ----- hdl/jd2c_in_if.sv -----
// Input channel of the converter: one Julian date word per handshake.
// Depends on jd2c_pkg.
interface jd2c_in_if
	import jd2c_pkg::*;
();
	logic            valid;
	logic            ready;
	logic [JD_W-1:0] julian_date;

	modport source (output valid, output julian_date, input ready);
	modport sink   (input valid, input julian_date, output ready);
endinterface

// ----- hdl/jd2c_out_if.sv -----
// Output channel of the converter: one calendar date word per handshake.
// Depends on jd2c_pkg.
interface jd2c_out_if
	import jd2c_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [DAY_W-1:0]         day_of_month;
	logic [MONTH_W-1:0]       month_number;
	logic signed [YEAR_W-1:0] year_number;
	logic [FRAC_OUT_W-1:0]    day_fraction;

	modport source (output valid, output day_of_month, output month_number,
		output year_number, output day_fraction, input ready);
	modport sink   (input valid, input day_of_month, input month_number,
		input year_number, input day_fraction, output ready);
endinterface

// ----- hdl/jd2c_cdiv.sv -----
// Pipelined floor division of an unsigned word by a constant, one digit per stage,
// with a sideband word carried alongside. Depends on jd2c_pkg.
module jd2c_cdiv
	import jd2c_pkg::*;
#(
	parameter int NUM_W   = 26,
	parameter int DIVISOR = ALPHA_DIV,
	parameter int SIDE_W  = 8,
	parameter int DIG_W   = DIGIT_W
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      en,
	input  logic                                      in_valid,
	input  logic [NUM_W-1:0]                          in_num,
	input  logic [SIDE_W-1:0]                         in_side,
	output logic                                      out_valid,
	output logic [NUM_W-$clog2(DIVISOR+1):0]          out_quo,
	output logic [SIDE_W-1:0]                         out_side
);

	localparam int DIV_W  = $clog2(DIVISOR + 1);
	localparam int QUO_W  = NUM_W - DIV_W + 1;
	localparam int STAGES = (NUM_W + DIG_W - 1) / DIG_W;
	localparam int PAD_W  = STAGES * DIG_W;
	localparam int T_W    = DIV_W + DIG_W;
	localparam int NMULT  = 2 ** DIG_W;

	function automatic logic [T_W-1:0] mult(input int k);
		return T_W'(k * DIVISOR);
	endfunction

	// stage registers
	logic              v_s    [STAGES];
	logic [PAD_W-1:0]  num_s  [STAGES];
	logic [DIV_W-1:0]  rem_s  [STAGES];
	logic [QUO_W-1:0]  quo_s  [STAGES];
	logic [SIDE_W-1:0] side_s [STAGES];

	// stage inputs and next values
	logic              src_v    [STAGES];
	logic [PAD_W-1:0]  src_num  [STAGES];
	logic [DIV_W-1:0]  src_rem  [STAGES];
	logic [QUO_W-1:0]  src_quo  [STAGES];
	logic [SIDE_W-1:0] src_side [STAGES];
	logic [PAD_W-1:0]  nxt_num  [STAGES];
	logic [DIV_W-1:0]  nxt_rem  [STAGES];
	logic [QUO_W-1:0]  nxt_quo  [STAGES];

	always_comb begin
		src_v[0]    = in_valid;
		src_num[0]  = PAD_W'(in_num);
		src_rem[0]  = '0;
		src_quo[0]  = '0;
		src_side[0] = in_side;
		for (int i = 1; i < STAGES; i++) begin
			src_v[i]    = v_s[i-1];
			src_num[i]  = num_s[i-1];
			src_rem[i]  = rem_s[i-1];
			src_quo[i]  = quo_s[i-1];
			src_side[i] = side_s[i-1];
		end
	end

	// one quotient digit per stage: largest multiple that fits
	always_comb begin
		logic [T_W-1:0]         t;
		logic [T_W-1:0]         sub;
		logic [T_W-1:0]         diff;
		logic [DIG_W-1:0]       q;
		logic [QUO_W+DIG_W-1:0] qx;
		for (int i = 0; i < STAGES; i++) begin
			t   = {src_rem[i], src_num[i][PAD_W-1 -: DIG_W]};
			q   = '0;
			sub = '0;
			for (int k = 1; k < NMULT; k++) begin
				if (t >= mult(k)) begin
					q   = DIG_W'(k);
					sub = mult(k);
				end
			end
			diff       = t - sub;
			qx         = {src_quo[i], q};
			nxt_rem[i] = diff[DIV_W-1:0];
			nxt_quo[i] = qx[QUO_W-1:0];
			nxt_num[i] = src_num[i] << DIG_W;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STAGES; i++) begin
				v_s[i] <= 1'b0;
			end
		end else if (en) begin
			for (int i = 0; i < STAGES; i++) begin
				v_s[i] <= src_v[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < STAGES; i++) begin
				num_s[i]  <= nxt_num[i];
				rem_s[i]  <= nxt_rem[i];
				quo_s[i]  <= nxt_quo[i];
				side_s[i] <= src_side[i];
			end
		end
	end

	assign out_valid = v_s[STAGES-1];
	assign out_quo   = quo_s[STAGES-1];
	assign out_side  = side_s[STAGES-1];

endmodule

// ----- hdl/julian_day_to_calendar_date.sv -----
// Julian date to calendar date converter, fully pipelined.
// Depends on jd2c_pkg, jd2c_in_if, jd2c_out_if and jd2c_cdiv.
//
// Usage:
//  - jdate carries one Julian date word per handshake (valid && ready):
//    unsigned fixed point with FRACTION_BITS fraction bits.
//  - cal returns one word per date, in order: day, month, astronomical
//    year (two's complement) and the fraction of the day since midnight
//    with 16 fraction bits.
//  - Throughput: one date per cycle while cal takes every word. The pipe
//    runs from acceptance through s1..s7 and the two constant long
//    dividers (one 4-bit quotient digit per stage) to the word on cal.
//  - Stall: the whole pipe advances on one enable. While cal holds a word
//    that is not taken, nothing moves and jdate.ready is low; no word is
//    lost or repeated. cal is driven straight from the last stage register.
//  - Reset (arst_n low) clears all valid bits; data registers keep
//    whatever they hold. There is no other state.
//
// Stages: s1 add half a day and split; s2 Gregorian test and alpha
// numerator; alpha divider; s3 day number b; s4 numerator of c; c divider;
// s5 b - d; s6 month index e; s7 output word.
module julian_day_to_calendar_date
	import jd2c_pkg::*;
#(
	parameter int FRACTION_BITS = FRAC_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	jd2c_in_if.sink     jdate,
	jd2c_out_if.source  cal
);

	localparam int SUM_W  = JD_W + 1;
	localparam int ZW     = SUM_W - FRACTION_BITS;
	localparam int GW     = ZW + $clog2(GREG_START + 1);
	localparam int ANUM_W = ZW + 2;
	localparam int AQ_W   = ANUM_W - $clog2(ALPHA_DIV + 1) + 1;
	localparam int B_W    = ZW + 1;
	localparam int CNUM_W = B_W + 7;
	localparam int CQ_W   = CNUM_W - $clog2(C_DIV + 1) + 1;
	localparam int AS_W   = 1 + ZW + FRAC_OUT_W;
	localparam int CS_W   = BD_W + FRAC_OUT_W;

	localparam logic [SUM_W-1:0] HALF_DAY = SUM_W'(1) << (FRACTION_BITS - 1);

	logic en;

	// global advance: last stage empty or being taken
	assign en          = !cal.valid || cal.ready;
	assign jdate.ready = en;

	// ---- s1: add half a day, split into day number and fraction ----
	logic [SUM_W-1:0]              sum;
	logic [FRACTION_BITS+FRAC_OUT_W-1:0] frac_x;
	logic                          v_s1;
	logic [ZW-1:0]                 z_s1;
	logic [FRAC_OUT_W-1:0]         frac_s1;

	assign sum    = SUM_W'(jdate.julian_date) + HALF_DAY;
	// top 16 bits of the fraction, zero padded when it is narrower
	assign frac_x = {sum[FRACTION_BITS-1:0], FRAC_OUT_W'(0)};

	// ---- s2: Gregorian test and alpha numerator ----
	logic [GW-1:0]         z_ext;
	logic                  greg;
	logic                  v_s2;
	logic                  greg_s2;
	logic [ANUM_W-1:0]     anum_s2;
	logic [ZW-1:0]         z_s2;
	logic [FRAC_OUT_W-1:0] frac_s2;

	assign z_ext = GW'(z_s1);
	assign greg  = z_ext >= GW'(GREG_START);

	// ---- alpha = floor((4z - 7468865) / 146097) ----
	logic              va;
	logic [AQ_W-1:0]   alpha;
	logic [AS_W-1:0]   aside;
	logic              greg_a;
	logic [ZW-1:0]     z_a;
	logic [FRAC_OUT_W-1:0] frac_a;

	jd2c_cdiv #(
		.NUM_W   (ANUM_W),
		.DIVISOR (ALPHA_DIV),
		.SIDE_W  (AS_W)
	) u_alpha_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.in_num    (anum_s2),
		.in_side   ({greg_s2, z_s2, frac_s2}),
		.out_valid (va),
		.out_quo   (alpha),
		.out_side  (aside)
	);

	assign {greg_a, z_a, frac_a} = aside;

	// ---- s3: b = a + 1524 ----
	logic [B_W-1:0]        corr;
	logic                  v_s3;
	logic [B_W-1:0]        b_s3;
	logic [FRAC_OUT_W-1:0] frac_s3;

	assign corr = B_W'(alpha) - B_W'(alpha >> 2);

	// ---- s4: c numerator, 100b - 12210, as shift-adds ----
	logic [CNUM_W-1:0]     b_ext;
	logic                  v_s4;
	logic [CNUM_W-1:0]     cnum_s4;
	logic [BD_W-1:0]       blo_s4;
	logic [FRAC_OUT_W-1:0] frac_s4;

	assign b_ext = CNUM_W'(b_s3);

	// ---- c = floor((100b - 12210) / 36525) ----
	logic                  vc;
	logic [CQ_W-1:0]       cq;
	logic [CS_W-1:0]       cside;
	logic [BD_W-1:0]       blo_c;
	logic [FRAC_OUT_W-1:0] frac_c;

	jd2c_cdiv #(
		.NUM_W   (CNUM_W),
		.DIVISOR (C_DIV),
		.SIDE_W  (CS_W)
	) u_c_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_num    (cnum_s4),
		.in_side   ({blo_s4, frac_s4}),
		.out_valid (vc),
		.out_quo   (cq),
		.out_side  (cside)
	);

	assign {blo_c, frac_c} = cside;

	// ---- s5: b - d, with d = floor(1461c / 4) taken mod 512 ----
	logic [CQ_W+YEAR_W-1:0] c_ext;
	logic [BD_W+1:0]        dprod;
	logic                   v_s5;
	logic [BD_W-1:0]        bd_s5;
	logic [YEAR_W-1:0]      c16_s5;
	logic [FRAC_OUT_W-1:0]  frac_s5;

	assign c_ext = {YEAR_W'(0), cq};
	assign dprod = c_ext[BD_W+1:0] * (BD_W+2)'(D_MUL);

	// ---- s6: month index e = largest k with 30.6001k <= b - d ----
	logic [MONTH_W-1:0]    e_idx;
	logic                  v_s6;
	logic [MONTH_W-1:0]    e_s6;
	logic [BD_W-1:0]       bd_s6;
	logic [YEAR_W-1:0]     c16_s6;
	logic [FRAC_OUT_W-1:0] frac_s6;

	always_comb begin
		e_idx = '0;
		for (int k = 1; k < 16; k++) begin
			if (bd_s5 > DAY_OFS[k]) begin
				e_idx = MONTH_W'(k);
			end
		end
	end

	// ---- s7: day, month, year ----
	logic [BD_W-1:0]    day_full;
	logic [MONTH_W-1:0] month;
	logic [YEAR_W-1:0]  year;
	logic               v_s7;

	assign day_full = bd_s6 - DAY_OFS[e_s6];
	assign month    = (e_s6 < MONTH_W'(14)) ? (e_s6 - MONTH_W'(1)) : (e_s6 - MONTH_W'(13));
	assign year     = (month > MONTH_W'(2)) ? (c16_s6 - YEAR_W'(YEAR_OFS_LATE))
	                                        : (c16_s6 - YEAR_W'(YEAR_OFS_EARLY));

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= jdate.valid;
			v_s2 <= v_s1;
			v_s3 <= va;
			v_s4 <= v_s3;
			v_s5 <= vc;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// data path
	always_ff @(posedge clk) begin
		if (en) begin
			z_s1    <= sum[SUM_W-1:FRACTION_BITS];
			frac_s1 <= frac_x[FRACTION_BITS+FRAC_OUT_W-1 -: FRAC_OUT_W];

			greg_s2 <= greg;
			// only used on the Gregorian side, where it is positive
			anum_s2 <= greg ? ({z_s1, 2'b00} - ANUM_W'(ALPHA_OFS)) : '0;
			z_s2    <= z_s1;
			frac_s2 <= frac_s1;

			b_s3    <= greg_a ? (B_W'(z_a) + B_W'(B_OFS + 1) + corr)
			                  : (B_W'(z_a) + B_W'(B_OFS));
			frac_s3 <= frac_a;

			cnum_s4 <= (b_ext << 6) + (b_ext << 5) + (b_ext << 2) - CNUM_W'(C_OFS);
			blo_s4  <= b_s3[BD_W-1:0];
			frac_s4 <= frac_s3;

			bd_s5   <= blo_c - dprod[BD_W+1:2];
			c16_s5  <= c_ext[YEAR_W-1:0];
			frac_s5 <= frac_c;

			e_s6    <= e_idx;
			bd_s6   <= bd_s5;
			c16_s6  <= c16_s5;
			frac_s6 <= frac_s5;

			cal.day_of_month <= day_full[DAY_W-1:0];
			cal.month_number <= month;
			cal.year_number  <= year;
			cal.day_fraction <= frac_s6;
		end
	end

	assign cal.valid = v_s7;

endmodule

// ----- test/tb.sv -----
// Self-checking bench for julian_day_to_calendar_date: directed date table, then random dates.
// Needs jd2c_pkg, jd2c_in_if, jd2c_out_if and the converter itself.
// Expected words come from a local model of the calendar arithmetic.
module tb;
	import jd2c_pkg::*;

	localparam int FB           = FRAC_BITS_DEFAULT;
	localparam int N_RANDOM     = 530;
	localparam int N_TAIL_CALM  = 60;   // last dates sent with no idling on either side
	localparam int TAIL_CYCLES  = 40;   // extra watch for stray words after the last drain
	localparam int LIMIT_CYCLES = 200000;

	// constants of the month split
	localparam longint MONTH_SCALE = 10000;
	localparam longint MONTH_DIV   = 306001;

	// one calendar word as it leaves the converter
	typedef struct packed {
		logic [DAY_W-1:0]         day;
		logic [MONTH_W-1:0]       month;
		logic signed [YEAR_W-1:0] year;
		logic [FRAC_OUT_W-1:0]    frac;
	} cal_word_t;

	// one row of the directed table; want is only used where known is set
	typedef struct packed {
		logic [JD_W-1:0] jd;
		bit              known;
		cal_word_t       want;
	} date_row_t;

	logic clk;
	logic arst_n;

	jd2c_in_if  jdate();
	jd2c_out_if cal();

	julian_day_to_calendar_date #(
		.FRACTION_BITS(FB)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.jdate  (jdate),
		.cal    (cal)
	);

	cal_word_t pending_dates[$];  // calendar words still owed by the pipe, oldest first
	cal_word_t next_date;         // expectation for the word now offered on jdate
	int        err_count;
	bit        tail_calm;         // no idling on either side once set

	// Directed dates: the zero input, the calendar switch, leap rules,
	// year zero, and both ends of the input range.
	date_row_t date_rows [18] = '{
		'{{23'd0, 16'h0000},       1'b1, '{5'd1, 4'd1, -16'sd4712, 16'h8000}},
		'{{23'd0, 16'h0001},       1'b0, '0},
		'{{23'd0, 16'h7FFF},       1'b0, '0},
		'{{23'd0, 16'h8000},       1'b0, '0},
		'{{23'd365, 16'h8000},     1'b0, '0},
		'{{23'd2451545, 16'h0000}, 1'b1, '{5'd1, 4'd1, 16'sd2000, 16'h8000}},
		'{{23'd2299160, 16'h8000}, 1'b1, '{5'd15, 4'd10, 16'sd1582, 16'h0000}},
		'{{23'd2299159, 16'h8000}, 1'b1, '{5'd4, 4'd10, 16'sd1582, 16'h0000}},
		'{{23'd2299160, 16'h7FFF}, 1'b0, '0},
		'{{23'd2451603, 16'h8000}, 1'b0, '0},
		'{{23'd2415079, 16'h8000}, 1'b0, '0},
		'{{23'd1721057, 16'h8000}, 1'b0, '0},
		'{{23'd1721423, 16'h4000}, 1'b0, '0},
		'{{23'd2460000, 16'hC000}, 1'b0, '0},
		'{{23'h555555, 16'h5555},  1'b0, '0},
		'{{23'h2AAAAA, 16'hAAAA},  1'b0, '0},
		'{{23'h7FFFFF, 16'h7FFF},  1'b0, '0},
		'{{23'h7FFFFF, 16'hFFFF},  1'b0, '0}
	};

	// Calendar date of a Julian date: shift to midnight, split off the day
	// fraction, then the usual day number to date chain with integer floors.
	function automatic cal_word_t to_calendar(input logic [JD_W-1:0] jd);
		longint shifted, z, frac, alpha, a, b, c, d, e, dd, mm, yy, frac16;
		cal_word_t w;
		shifted = longint'(jd) + (longint'(1) << (FB - 1));
		z       = shifted >> FB;
		frac    = shifted & ((longint'(1) << FB) - 1);
		if (z < GREG_START) begin
			a = z;
		end else begin
			alpha = (4 * z - ALPHA_OFS) / ALPHA_DIV;
			a     = z + 1 + alpha - alpha / 4;
		end
		b  = a + B_OFS;
		c  = (100 * b - C_OFS) / C_DIV;
		d  = (D_MUL * c) / 4;
		e  = (MONTH_SCALE * (b - d)) / MONTH_DIV;
		dd = b - d - (MONTH_DIV * e) / MONTH_SCALE;
		mm = (e < 14) ? e - 1 : e - 13;
		yy = (mm > 2) ? c - YEAR_OFS_LATE : c - YEAR_OFS_EARLY;
		if (FB >= 16) begin
			frac16 = frac >> (FB - 16);
		end else begin
			frac16 = frac << (16 - FB);
		end
		w.day   = dd[DAY_W-1:0];
		w.month = mm[MONTH_W-1:0];
		w.year  = yy[YEAR_W-1:0];
		w.frac  = frac16[FRAC_OUT_W-1:0];
		return w;
	endfunction

	// Random date, weighted toward places where the arithmetic turns:
	// around the calendar switch, the historic range, near day zero and
	// near the top of the range. A share is fully random over all 39 bits.
	function automatic logic [JD_W-1:0] random_date();
		logic [63:0] raw;
		longint      z;
		int          pick;
		raw  = {$urandom, $urandom};
		pick = $urandom_range(0, 9);
		case (pick)
			0, 1, 2, 3: begin
				return raw[JD_W-1:0];
			end
			4, 5: begin
				z = GREG_START + $urandom_range(0, 400) - 200;
			end
			6, 7: begin
				z = $urandom_range(1500000, 2600000);
			end
			8: begin
				z = $urandom_range(0, 1500);
			end
			default: begin
				z = (longint'(1) << (JD_W - FB)) - 1 - $urandom_range(0, 1500);
			end
		endcase
		return JD_W'((z << FB) | (raw & ((longint'(1) << FB) - 1)));
	endfunction

	// One line per mismatch, counted for the final verdict.
	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d, want %0d", what, got, want);
		err_count++;
	endtask

	// Offer one date word at the current falling edge and hold it until the
	// converter takes it; returns on the falling edge after acceptance.
	task automatic offer_date(input logic [JD_W-1:0] jd, input cal_word_t want);
		next_date = want;
		jdate.valid       <= 1'b1;
		jdate.julian_date <= jd;
		do @(posedge clk); while (!jdate.ready);
		@(negedge clk);
	endtask

	// Drop valid and wait until the pipe has delivered every owed word.
	task automatic drain_pipe();
		jdate.valid <= 1'b0;
		do @(negedge clk); while (pending_dates.size() != 0);
	endtask

	// Clock: period 4.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run-away guard.
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("FAILED: results differ");
		$finish;
	end

	// Scoreboard, sampled at the rising edge. A word accepted on jdate owes
	// one calendar word; each word taken on cal must match the oldest one.
	always @(posedge clk) begin
		cal_word_t want;
		if (jdate.valid && jdate.ready) begin
			pending_dates.insert(pending_dates.size(), next_date);
		end
		if (cal.valid && cal.ready) begin
			if (pending_dates.size() == 0) begin
				flag_mismatch("unexpected word, day", cal.day_of_month, 0);
			end else begin
				want = pending_dates.pop_front();
				if (cal.day_of_month !== want.day) begin
					flag_mismatch("day_of_month", cal.day_of_month, want.day);
				end
				if (cal.month_number !== want.month) begin
					flag_mismatch("month_number", cal.month_number, want.month);
				end
				if (cal.year_number !== want.year) begin
					flag_mismatch("year_number", cal.year_number, want.year);
				end
				if (cal.day_fraction !== want.frac) begin
					flag_mismatch("day_fraction", cal.day_fraction, want.frac);
				end
			end
		end
	end

	// Receiver: ready high or low in random bursts, changed on the falling
	// edge; once the tail starts it goes high after the current run and stays high.
	initial begin
		int run;
		cal.ready = 1'b0;
		@(negedge clk);
		forever begin
			if (tail_calm || $urandom_range(0, 2) != 0) begin
				cal.ready <= 1'b1;
				run = $urandom_range(1, 30);
			end else begin
				cal.ready <= 1'b0;
				run = $urandom_range(1, 11);
			end
			repeat (run) @(negedge clk);
		end
	end

	// Sender and run control.
	initial begin
		bit              calm;
		int              gap;
		date_row_t       row;
		logic [JD_W-1:0] jd;
		err_count         = 0;
		tail_calm         = 1'b0;
		calm              = 1'b0;
		next_date         = '0;
		arst_n            = 1'b0;
		jdate.valid       = 1'b0;
		jdate.julian_date = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table; rows without a typed answer go through the model
		foreach (date_rows[i]) begin
			row = date_rows[i];
			offer_date(row.jd, row.known ? row.want : to_calendar(row.jd));
			if ($urandom_range(0, 2) == 0) begin
				jdate.valid <= 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end
		end

		// hold the sender until the pipe is empty
		drain_pipe();

		// random dates; calm stretches now and then, a full drain halfway,
		// and no idling at all over the last stretch
		for (int k = 0; k < N_RANDOM; k++) begin
			if (k == N_RANDOM / 2) begin
				drain_pipe();
			end
			if (k % 50 == 0) begin
				calm = ($urandom_range(0, 3) == 0);
			end
			if (k == N_RANDOM - N_TAIL_CALM) begin
				tail_calm = 1'b1;
			end
			jd = random_date();
			offer_date(jd, to_calendar(jd));
			if (!tail_calm && !calm && $urandom_range(0, 2) == 0) begin
				gap = $urandom_range(1, 11);
				jdate.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end

		// let the pipe empty, then watch a little longer for stray words
		drain_pipe();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (pending_dates.size() != 0) begin
			flag_mismatch("words never delivered", 0, pending_dates.size());
		end

		if (err_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
